FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define RTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define RTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTC_ASSERT(lbl, prop, msg)
`define RTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/rtc_pkg.sv
// ---------------------------------------------------------------------------
// rtc_pkg
// Shared constants for the RTD code to temperature pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;

  // register indexes
  localparam logic CFG_REFERENCE = 1'b0;
  localparam logic CFG_NOMINAL   = 1'b1;

  localparam logic [15:0] REF_RESET = 16'd430;
  localparam logic [11:0] NOM_RESET = 12'd100;

  localparam int DIV_STAGES  = 20;  // two quotient bits per stage, 40 bits
  localparam int SQRT_STAGES = 10;  // two root bits per stage, 20 bits
  localparam int POLY_STAGES = 6;   // five multiply-adds and a rounding stage
  // two multiply stages and root, after the cap
  localparam int ROOT_PATH   = 2 + SQRT_STAGES;
  localparam int POLY_DLY    = ROOT_PATH - POLY_STAGES;
  localparam int FAULT_DLY   = 1 + DIV_STAGES + 1 + ROOT_PATH;

  localparam logic [28:0] R_CAP  = 29'd268435456;   // 16.0 in Q24
  localparam logic [32:0] K_Q12  = 33'd7092640693;
  localparam logic [39:0] C0_Q16 = 40'd863880388610;
  localparam logic [20:0] A_Q8   = 21'd866255;

  localparam logic signed [21:0] TEMP_MAX = 22'sd262143;
  localparam logic signed [21:0] TEMP_MIN = -22'sd65536;

  // polynomial coefficients, Q24, already scaled by 100^k
  function automatic logic signed [35:0] poly_coef(input int k);
    logic signed [35:0] c;
    case (k)
      0:       c = -36'sd4060421816;
      1:       c = 36'sd3729239572;
      2:       c = 36'sd433842029;
      3:       c = -36'sd80966844;
      4:       c = -36'sd47283228;
      default: c = 36'sd25573510;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rtd_code_to_temperature_top.sv
// ---------------------------------------------------------------------------
// rtd_code_to_temperature_top
// Pt100-style RTD code to temperature converter, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one 16-bit RTD register word per transfer (bit 0 = fault).
//   out_* : one temperature (signed Q8, saturated) and fault flag per word.
//   cfg_* : write reference_ohms (index 0) or nominal_ohms (index 1) while
//           the pipeline is empty; takes effect on the next word.
// Throughput: one word per cycle while the output is not stalled.
// Pipeline: input stage, 20-stage divider (code * Rref / Rnom), cap, two
//   multiply stages, a 10-stage square root, and the output register. The
//   fifth-order fit for negative temperatures runs alongside the root and is
//   delayed to match.
// Reset: clears all valid bits and loads the default registers
//   (430 ohm reference, 100 ohm nominal).
// Stall: the whole pipe advances together; when the output holds a result
//   that is not taken, every stage freezes and in_ready drops, so nothing
//   is lost or repeated. Empty stages do not fill during a stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rtd_code_to_temperature_top import rtc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_rtd_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [18:0]      out_temperature,
  output logic                    out_fault,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  // configuration registers
  logic [15:0] ref_ohms_r;
  logic [11:0] nom_ohms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_ohms_r <= REF_RESET;
      nom_ohms_r <= NOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REFERENCE: ref_ohms_r <= cfg_wdata;
        CFG_NOMINAL:   nom_ohms_r <= cfg_wdata[11:0];
      endcase
    end
  end

  // zero nominal acts as one
  logic [11:0] nom_eff;
  assign nom_eff = (nom_ohms_r == '0) ? 12'd1 : nom_ohms_r;

  // global advance: output slot empty or being taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input stage: code * Rref
  logic        v0_r;
  logic [30:0] num0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  // full 31-bit product
  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= {16'd0, in_rtd_word[15:1]} * ref_ohms_r;
    end
  end

  // ratio r in Q24
  logic        div_valid;
  logic [39:0] div_quo;

  rtc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .in_num    (num0_r),
    .nom       (nom_eff),
    .out_valid (div_valid),
    .out_quo   (div_quo)
  );

  // cap at 16.0
  logic        v1_r;
  logic [28:0] r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= (div_quo > {11'd0, R_CAP}) ? R_CAP : div_quo[28:0];
    end
  end

  // K * r split in two partial products
  logic        vm1_r;
  logic [47:0] pl_r;
  logic [46:0] ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else if (en) begin
      vm1_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= K_Q12 * r1_r[14:0];
      ph_r <= K_Q12 * r1_r[28:15];
    end
  end

  // root argument, clamped at zero
  logic        vm2_r;
  logic [39:0] arg_r;
  logic [62:0] kr_sum;
  logic [42:0] kr_q;

  assign kr_sum = {1'b0, ph_r, 15'd0} + {15'd0, pl_r};
  assign kr_q   = kr_sum[62:20];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else if (en) begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg_r <= (kr_q > {3'd0, C0_Q16}) ? '0 : 40'(C0_Q16 - kr_q[39:0]);
    end
  end

  logic        sq_valid;
  logic [19:0] sq_root;

  rtc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vm2_r),
    .in_arg    (arg_r),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  // polynomial path, fed from the capped ratio
  logic signed [21:0] poly_t;

  rtc_poly u_poly (
    .clk   (clk),
    .en    (en),
    .in_r  (r1_r[23:0]),
    .out_t (poly_t)
  );

  logic signed [21:0] pd_r [POLY_DLY];

  for (genvar i = 0; i < POLY_DLY; i++) begin : g_pdly
    always_ff @(posedge clk) begin
      if (en) begin
        pd_r[i] <= (i == 0) ? poly_t : pd_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // fault flag follows the data
  logic fault_r [FAULT_DLY];

  for (genvar i = 0; i < FAULT_DLY; i++) begin : g_fdly
    always_ff @(posedge clk) begin
      if (en) begin
        fault_r[i] <= (i == 0) ? in_rtd_word[0] : fault_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // select, saturate, output register
  logic signed [21:0] t_sq;
  logic signed [21:0] t_sel;
  logic signed [18:0] t_sat;

  assign t_sq  = $signed({1'b0, A_Q8}) - $signed({2'b00, sq_root});
  assign t_sel = t_sq[21] ? pd_r[POLY_DLY-1] : t_sq;

  always_comb begin
    if (t_sel > TEMP_MAX) t_sat = TEMP_MAX[18:0];
    else if (t_sel < TEMP_MIN) t_sat = TEMP_MIN[18:0];
    else t_sat = t_sel[18:0];
  end

  logic               out_valid_r;
  logic signed [18:0] out_temp_r;
  logic               out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_fault_r <= fault_r[FAULT_DLY-1];
      out_temp_r  <= fault_r[FAULT_DLY-1] ? '0 : t_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_fault       = out_fault_r;

  `RTC_ASSERT(a_fault_zero, out_valid && out_fault |-> out_temperature == '0, "fault with nonzero temperature")
  `RTC_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_valid, "valid out right after reset")
  `RTC_ASSERT(a_stall_blocks, out_valid && !out_ready |-> !in_ready, "input taken during stall")

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_div.sv
// ---------------------------------------------------------------------------
// rtc_div
// Pipelined restoring divider, 40-bit dividend by 12-bit divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtc_div import rtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [30:0] in_num,
  input  wire logic [11:0] nom,
  output logic             out_valid,
  output logic [39:0]      out_quo
);

  // one quotient bit; quotient bits shift into the freed dividend bits
  function automatic logic [51:0] div_step(input logic [11:0] rem, input logic [39:0] dq,
                                           input logic [11:0] d);
    logic [12:0] t;
    logic [12:0] s;
    t = {rem, dq[39]};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) return {s[11:0], dq[38:0], 1'b1};
    else return {t[11:0], dq[38:0], 1'b0};
  endfunction

  logic        vld_r [DIV_STAGES];
  logic [11:0] rem_r [DIV_STAGES];
  logic [39:0] dq_r  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic        vld_in;
    logic [51:0] mid;
    logic [51:0] fin;
    logic [11:0] rem_in;
    logic [39:0] dq_in;
    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = '0;
      assign dq_in  = {in_num, 9'd0};
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign dq_in  = dq_r[s-1];
    end
    assign mid = div_step(rem_in, dq_in, nom);
    assign fin = div_step(mid[51:40], mid[39:0], nom);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= fin[51:40];
        dq_r[s]  <= fin[39:0];
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_quo   = dq_r[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_sqrt.sv
// ---------------------------------------------------------------------------
// rtc_sqrt
// Pipelined digit-by-digit floor square root of a 40-bit value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtc_sqrt import rtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [39:0] in_arg,
  output logic             out_valid,
  output logic [19:0]      out_root
);

  // {rem, root, arg}
  function automatic logic [81:0] sq_step(input logic [21:0] rem, input logic [19:0] root,
                                          input logic [39:0] a);
    logic [23:0] t;
    logic [23:0] trial;
    logic [23:0] d;
    t     = {rem, a[39:38]};
    trial = {2'b00, root, 2'b01};
    d     = t - trial;
    if (t >= trial) return {d[21:0], root[18:0], 1'b1, a[37:0], 2'b00};
    else return {t[21:0], root[18:0], 1'b0, a[37:0], 2'b00};
  endfunction

  logic        vld_r  [SQRT_STAGES];
  logic [21:0] rem_r  [SQRT_STAGES];
  logic [19:0] root_r [SQRT_STAGES];
  logic [39:0] a_r    [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic        vld_in;
    logic [21:0] rem_in;
    logic [19:0] root_in;
    logic [39:0] a_in;
    logic [81:0] mid;
    logic [81:0] fin;
    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign a_in    = in_arg;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign a_in    = a_r[s-1];
    end
    assign mid = sq_step(rem_in, root_in, a_in);
    assign fin = sq_step(mid[81:60], mid[59:40], mid[39:0]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= fin[81:60];
        root_r[s] <= fin[59:40];
        a_r[s]    <= fin[39:0];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];

endmodule
`default_nettype wire

FILE: hw/rtl/rtc_poly.sv
// ---------------------------------------------------------------------------
// rtc_poly
// Fifth-order Horner pipeline in Q24, rounded to Q8 at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtc_poly import rtc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [23:0]        in_r,
  output logic signed [21:0]      out_t
);

  localparam int MACS = POLY_STAGES - 1;

  logic signed [35:0] acc_r [MACS];
  logic [23:0]        r_r   [MACS];
  logic signed [21:0] t_r;

  for (genvar s = 0; s < MACS; s++) begin : g_mac
    logic signed [35:0] acc_in;
    logic [23:0]        r_in;
    logic signed [60:0] prod;
    logic signed [35:0] acc_nxt;
    if (s == 0) begin : g_first
      assign acc_in = poly_coef(MACS);
      assign r_in   = in_r;
    end else begin : g_next
      assign acc_in = acc_r[s-1];
      assign r_in   = r_r[s-1];
    end
    // arithmetic shift of the product is the floor
    assign prod    = acc_in * $signed({1'b0, r_in});
    assign acc_nxt = $signed(prod[59:24]) + poly_coef(MACS - 1 - s);

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[s] <= acc_nxt;
        r_r[s]   <= r_in;
      end
    end
  end

  logic signed [35:0] rnd;
  assign rnd = acc_r[MACS-1] + 36'sd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= {{2{rnd[35]}}, rnd[35:16]};
    end
  end

  assign out_t = t_r;

endmodule
`default_nettype wire
